>>> src/pixrs_pkg.sv
// ----------------------------------------------------------------------------
// pixrs_pkg
// Shared types and constants for the pixel replicate scaler.
// ----------------------------------------------------------------------------
package pixrs_pkg;

  localparam int FRAC_W     = 16;  // fraction bits of the scale factors
  localparam int ACC_W      = 30;  // position accumulators
  localparam int COORD_W    = 13;  // destination coordinates
  localparam int PIX_W      = 16;
  localparam int SCALE_W    = 20;
  localparam int SIZE_REG_W = 11;
  localparam int SZ_W       = 13;  // holds any effective size up to 4096
  localparam int RUN_W      = 4;   // run length 0..8
  localparam int OFS_W      = 3;   // offset inside a run 0..7
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [SCALE_W-1:0] ONE_FIX_M1 = SCALE_W'((1 << FRAC_W) - 1);

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SCALE_X       = 2'd2,
    REG_SCALE_Y       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_REG_W-1:0] source_width;
    logic [SIZE_REG_W-1:0] source_height;
    logic [SCALE_W-1:0]    scale_x;
    logic [SCALE_W-1:0]    scale_y;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;  // take the item, latch run, advance counters
    logic step;  // move to the next write of the run
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_zero;  // current config yields no writes
    logic last;      // offsets sit on the final write
  } dp_stat_t;

endpackage

>>> src/pixrs_regs.sv
// ----------------------------------------------------------------------------
// pixrs_regs
// APB configuration registers: source size and scale factors.
// ----------------------------------------------------------------------------
module pixrs_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pixrs_pkg::APB_AW-1:0]     paddr,
  input  logic [pixrs_pkg::APB_DW-1:0]     pwdata,
  output logic [pixrs_pkg::APB_DW-1:0]     prdata,
  output logic                             pready,
  output pixrs_pkg::cfg_t                  cfg
);

  pixrs_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx    = pixrs_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= pixrs_pkg::SIZE_REG_W'(1);
      cfg.source_height <= pixrs_pkg::SIZE_REG_W'(1);
      cfg.scale_x       <= pixrs_pkg::SCALE_W'(1 << pixrs_pkg::FRAC_W);
      cfg.scale_y       <= pixrs_pkg::SCALE_W'(1 << pixrs_pkg::FRAC_W);
    end else if (wr_en) begin
      unique case (idx)
        pixrs_pkg::REG_SOURCE_WIDTH:
          cfg.source_width  <= pwdata[pixrs_pkg::SIZE_REG_W-1:0];
        pixrs_pkg::REG_SOURCE_HEIGHT:
          cfg.source_height <= pwdata[pixrs_pkg::SIZE_REG_W-1:0];
        pixrs_pkg::REG_SCALE_X:
          cfg.scale_x       <= pwdata[pixrs_pkg::SCALE_W-1:0];
        pixrs_pkg::REG_SCALE_Y:
          cfg.scale_y       <= pwdata[pixrs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pixrs_pkg::REG_SOURCE_WIDTH:  prdata = pixrs_pkg::APB_DW'(cfg.source_width);
      pixrs_pkg::REG_SOURCE_HEIGHT: prdata = pixrs_pkg::APB_DW'(cfg.source_height);
      pixrs_pkg::REG_SCALE_X:       prdata = pixrs_pkg::APB_DW'(cfg.scale_x);
      pixrs_pkg::REG_SCALE_Y:       prdata = pixrs_pkg::APB_DW'(cfg.scale_y);
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> src/pixrs_ctrl.sv
// ----------------------------------------------------------------------------
// pixrs_ctrl
// Controller: takes one item, then walks its run of writes.
// ----------------------------------------------------------------------------
module pixrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pixrs_pkg::dp_stat_t   stat,
  output pixrs_pkg::ctrl_cmd_t  cmd
);

  pixrs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pixrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pixrs_pkg::ST_IDLE: begin
        if (in_valid && !stat.run_zero) state_next = pixrs_pkg::ST_EMIT;
      end
      pixrs_pkg::ST_EMIT: begin
        if (out_ready && stat.last) state_next = pixrs_pkg::ST_IDLE;
      end
      default: state_next = pixrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      pixrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pixrs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !stat.last;
      end
      default: ;
    endcase
  end

endmodule

>>> src/pixrs_dp.sv
// ----------------------------------------------------------------------------
// pixrs_dp
// Datapath: position counters, accumulators and run offsets.
// ----------------------------------------------------------------------------
module pixrs_dp #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_FACTOR = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pixrs_pkg::cfg_t                  cfg,
  input  pixrs_pkg::ctrl_cmd_t             cmd,
  output pixrs_pkg::dp_stat_t              stat,
  input  logic [pixrs_pkg::PIX_W-1:0]      src_pixel,
  output logic [pixrs_pkg::COORD_W-1:0]    dest_x,
  output logic [pixrs_pkg::COORD_W-1:0]    dest_y,
  output logic [pixrs_pkg::PIX_W-1:0]      pixel_out
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam logic [pixrs_pkg::SZ_W-1:0]    DIM_LIM   = pixrs_pkg::SZ_W'(MAX_DIM);
  localparam logic [pixrs_pkg::SCALE_W-1:0] SCALE_LIM =
    pixrs_pkg::SCALE_W'(MAX_FACTOR * (1 << pixrs_pkg::FRAC_W));

  function automatic logic [pixrs_pkg::SZ_W-1:0] eff_size(
    input logic [pixrs_pkg::SIZE_REG_W-1:0] v
  );
    logic [pixrs_pkg::SZ_W-1:0] ve;
    ve = pixrs_pkg::SZ_W'(v);
    if (ve == '0) return pixrs_pkg::SZ_W'(1);
    if (ve > DIM_LIM) return DIM_LIM;
    return ve;
  endfunction

  logic [CNT_W-1:0]              column_count, row_count;
  logic [pixrs_pkg::ACC_W-1:0]   x_accumulator, y_accumulator;

  logic [pixrs_pkg::SCALE_W-1:0] sx, sy, sx_up, sy_up;
  logic [pixrs_pkg::RUN_W-1:0]   run_x, run_y;
  logic [pixrs_pkg::SZ_W-1:0]    w_eff, h_eff, col_inc, row_inc;

  // per-item payload
  logic [pixrs_pkg::COORD_W-1:0] base_x, base_y;
  logic [pixrs_pkg::OFS_W-1:0]   run_x_m1, run_y_m1, ox, oy;
  logic [pixrs_pkg::PIX_W-1:0]   pix;

  always_comb begin
    sx      = (cfg.scale_x > SCALE_LIM) ? SCALE_LIM : cfg.scale_x;
    sy      = (cfg.scale_y > SCALE_LIM) ? SCALE_LIM : cfg.scale_y;
    // ceil of the factor; sums stay below 2^20
    sx_up   = sx + pixrs_pkg::ONE_FIX_M1;
    sy_up   = sy + pixrs_pkg::ONE_FIX_M1;
    run_x   = sx_up[pixrs_pkg::SCALE_W-1:pixrs_pkg::FRAC_W];
    run_y   = sy_up[pixrs_pkg::SCALE_W-1:pixrs_pkg::FRAC_W];
    w_eff   = eff_size(cfg.source_width);
    h_eff   = eff_size(cfg.source_height);
    col_inc = pixrs_pkg::SZ_W'(column_count) + pixrs_pkg::SZ_W'(1);
    row_inc = pixrs_pkg::SZ_W'(row_count) + pixrs_pkg::SZ_W'(1);
  end

  assign stat.run_zero = (run_x == '0) || (run_y == '0);
  assign stat.last     = (ox == run_x_m1) && (oy == run_y_m1);

  // raster position and running products
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      x_accumulator <= '0;
      y_accumulator <= '0;
    end else if (cmd.load) begin
      if (col_inc >= w_eff) begin
        column_count  <= '0;
        x_accumulator <= '0;
        if (row_inc >= h_eff) begin
          row_count     <= '0;
          y_accumulator <= '0;
        end else begin
          row_count     <= row_inc[CNT_W-1:0];
          y_accumulator <= y_accumulator + pixrs_pkg::ACC_W'(sy);
        end
      end else begin
        column_count  <= col_inc[CNT_W-1:0];
        x_accumulator <= x_accumulator + pixrs_pkg::ACC_W'(sx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix      <= src_pixel;
      base_x   <= x_accumulator[pixrs_pkg::FRAC_W +: pixrs_pkg::COORD_W];
      base_y   <= y_accumulator[pixrs_pkg::FRAC_W +: pixrs_pkg::COORD_W];
      run_x_m1 <= pixrs_pkg::OFS_W'(run_x - pixrs_pkg::RUN_W'(1));
      run_y_m1 <= pixrs_pkg::OFS_W'(run_y - pixrs_pkg::RUN_W'(1));
      ox       <= '0;
      oy       <= '0;
    end else if (cmd.step) begin
      if (ox == run_x_m1) begin
        ox <= '0;
        oy <= oy + pixrs_pkg::OFS_W'(1);
      end else begin
        ox <= ox + pixrs_pkg::OFS_W'(1);
      end
    end
  end

  assign dest_x    = base_x + pixrs_pkg::COORD_W'(ox);
  assign dest_y    = base_y + pixrs_pkg::COORD_W'(oy);
  assign pixel_out = pix;

endmodule

>>> src/pixel_replicate_scaler.sv
// ----------------------------------------------------------------------------
// pixel_replicate_scaler
// The first write is valid in the cycle after the item is taken. Each item
// gives ceil(scale_x)*ceil(scale_y) writes (none for a zero factor), emitted
// one per cycle while m_axis_tready is high; no item is taken until the run ends.
// Reset: synchronous; counters, accumulators and controller cleared,
// registers back to 1 x 1 source and unity factors.
// ----------------------------------------------------------------------------
module pixel_replicate_scaler #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_FACTOR = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pixrs_pkg::APB_AW-1:0]  paddr,
  input  logic [pixrs_pkg::APB_DW-1:0]  pwdata,
  output logic [pixrs_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  // source pixels
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // src_pixel[15:0]
  // destination writes
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,   // dest_x[12:0], dest_y[25:13],
                                                        // pixel_out[41:26], zero pad
  output logic                          m_axis_tlast    // last_of_run
);

  pixrs_pkg::cfg_t       cfg;
  pixrs_pkg::ctrl_cmd_t  cmd;
  pixrs_pkg::dp_stat_t   stat;

  logic [pixrs_pkg::COORD_W-1:0] dest_x, dest_y;
  logic [pixrs_pkg::PIX_W-1:0]   pixel_out;

  pixrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pixrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pixrs_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .src_pixel (s_axis_tdata),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .pixel_out (pixel_out)
  );

  assign m_axis_tdata = {6'd0, pixel_out, dest_y, dest_x};
  assign m_axis_tlast = stat.last;

endmodule

>>> sim/pixel_replicate_scaler_tb.sv
// ----------------------------------------------------------------------------
// pixel_replicate_scaler_tb
// Self-checking bench for the pixel replicate scaler. Source pixels go in on
// the input stream; a scoreboard mirrors the scaler's position counters and
// accumulators, expands each accepted pixel into its block of destination
// writes and checks every write on the output stream in order. Registers are
// reprogrammed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module pixel_replicate_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIM_LIMIT    = 1024;
  localparam int          FACTOR_LIMIT = 8;
  localparam int unsigned UNITY        = 32'h0001_0000;  // 1.0 in 16.16
  localparam int          DRAIN_CYCLES = 10;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          SEGMENTS     = 10;
  localparam int          SEG_ITEMS    = 30;

  typedef struct packed {
    logic        last;
    logic [15:0] pix;
    logic [12:0] y;
    logic [12:0] x;
  } dest_write_t;

  class scaler_scoreboard;
    logic [10:0]  src_w, src_h;
    logic [19:0]  scl_x, scl_y;
    int unsigned  col, row;
    logic [29:0]  x_acc, y_acc;
    dest_write_t  writes_q[$];
    int           errors;

    function new();
      src_w  = 11'd1;
      src_h  = 11'd1;
      scl_x  = 20'(UNITY);
      scl_y  = 20'(UNITY);
      col    = 0;
      row    = 0;
      x_acc  = '0;
      y_acc  = '0;
      errors = 0;
    endfunction

    function void set_reg(pixrs_pkg::reg_idx_t idx, logic [31:0] v);
      unique case (idx)
        pixrs_pkg::REG_SOURCE_WIDTH:  src_w = v[10:0];
        pixrs_pkg::REG_SOURCE_HEIGHT: src_h = v[10:0];
        pixrs_pkg::REG_SCALE_X:       scl_x = v[19:0];
        pixrs_pkg::REG_SCALE_Y:       scl_y = v[19:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [10:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
    endfunction

    function int unsigned clamp_scale(logic [19:0] v);
      int unsigned lim;
      lim = FACTOR_LIMIT * UNITY;
      return (v > lim) ? lim : v;
    endfunction

    function int pending();
      return writes_q.size();
    endfunction

    // expand one source pixel into its block of writes, then advance position
    function void note_pixel(logic [15:0] pix);
      int unsigned sx, sy, run_x, run_y, base_x, base_y;
      dest_write_t w;
      sx     = clamp_scale(scl_x);
      sy     = clamp_scale(scl_y);
      run_x  = (sx + UNITY - 1) >> 16;
      run_y  = (sy + UNITY - 1) >> 16;
      base_x = x_acc >> 16;
      base_y = y_acc >> 16;
      for (int unsigned oy = 0; oy < run_y; oy++) begin
        for (int unsigned ox = 0; ox < run_x; ox++) begin
          w.x    = 13'(base_x + ox);
          w.y    = 13'(base_y + oy);
          w.pix  = pix;
          w.last = (oy + 1 == run_y) && (ox + 1 == run_x);
          writes_q.push_back(w);
        end
      end
      if (col + 1 >= clamp_size(src_w)) begin
        col   = 0;
        x_acc = '0;
        if (row + 1 >= clamp_size(src_h)) begin
          row   = 0;
          y_acc = '0;
        end else begin
          row   = (row + 1) & 32'hFFFF;
          y_acc = y_acc + 30'(sy);
        end
      end else begin
        col   = (col + 1) & 32'hFFFF;
        x_acc = x_acc + 30'(sx);
      end
    endfunction

    function void check_write(logic [47:0] d, logic last);
      dest_write_t got, exp_w;
      got.x    = d[12:0];
      got.y    = d[25:13];
      got.pix  = d[41:26];
      got.last = last;
      if (writes_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected write x=%0d y=%0d pix=%h last=%b",
                   got.x, got.y, got.pix, got.last);
      end else begin
        exp_w = writes_q.pop_front();
        if (got !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: write mismatch exp x=%0d y=%0d pix=%h last=%b, ",
                      "got x=%0d y=%0d pix=%h last=%b"},
                     exp_w.x, exp_w.y, exp_w.pix, exp_w.last,
                     got.x, got.y, got.pix, got.last);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel, penable, pwrite;
  logic [pixrs_pkg::APB_AW-1:0]  paddr;
  logic [pixrs_pkg::APB_DW-1:0]  pwdata;
  logic [pixrs_pkg::APB_DW-1:0]  prdata;
  logic                          pready;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;   // src_pixel[15:0]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [47:0]                   m_axis_tdata;   // dest_x[12:0], dest_y[25:13],
                                                 // pixel_out[41:26], pad
  logic                          m_axis_tlast;   // last_of_run

  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  scaler_scoreboard   sb;

  pixel_replicate_scaler #(
    .MAX_DIM    (DIM_LIMIT),
    .MAX_FACTOR (FACTOR_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // input note first: a write can never belong to a pixel taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_write(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [15:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // wait for all writes, plus a margin for pixels that produce none
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pixrs_pkg::reg_idx_t idx, input logic [31:0] val);
    logic [31:0] data;
    data = val;
    // bits above the register width must be dropped
    if ($urandom_range(0, 3) == 0)
      data = data | ($urandom() &
                     ((idx == pixrs_pkg::REG_SCALE_X || idx == pixrs_pkg::REG_SCALE_Y) ?
                      32'hFFF0_0000 : 32'hFFFF_F800));
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] sx, input logic [31:0] sy);
    settle();
    write_reg(pixrs_pkg::REG_SOURCE_WIDTH, w);
    write_reg(pixrs_pkg::REG_SOURCE_HEIGHT, h);
    write_reg(pixrs_pkg::REG_SCALE_X, sx);
    write_reg(pixrs_pkg::REG_SCALE_Y, sy);
  endtask

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(1025, 2047);
    if (r <= 3) return $urandom_range(9, 300);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [31:0] rand_scale();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(524289, 20'hFFFFF);
    if (r == 2) return 524288;
    if (r <= 7) return $urandom_range(1, 65536);
    if (r <= 15) return $urandom_range(65537, 196608);
    return $urandom_range(196609, 524288);
  endfunction

  initial begin
    sb            = new();
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: 1x1 source, unity factors
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);

    // plain upscale, 2.0 x 1.5 over a 3x2 frame
    configure(3, 2, 2 * UNITY, 98304);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h0F0F);
    send_pixel(16'hF0F0);
    send_pixel(16'h00FF);
    send_pixel(16'hFF00);

    // oversize width, zero height, saturated and maximal factors: 64 writes per pixel
    configure(2047, 0, 20'hFFFFF, FACTOR_LIMIT * UNITY);
    send_pixel(16'h1234);
    send_pixel(16'hFEDC);

    // zero horizontal factor: no writes, counters still move
    configure(2047, 0, 0, 1);
    send_pixel(16'h8001);
    send_pixel(16'h7FFE);
    send_pixel(16'h3C3C);
    settle();
    write_reg(pixrs_pkg::REG_SCALE_X, 1);
    send_pixel(16'hC3C3);
    send_pixel(16'h6996);

    // shrink sizes under the running counters so they wrap early
    configure(6, 3, UNITY, UNITY);
    send_pixel(16'h0001);
    send_pixel(16'h0002);
    send_pixel(16'h0004);
    send_pixel(16'h0008);
    settle();
    write_reg(pixrs_pkg::REG_SOURCE_WIDTH, 2);
    send_pixel(16'h0010);
    send_pixel(16'h0020);
    send_pixel(16'h0040);
    settle();
    write_reg(pixrs_pkg::REG_SOURCE_HEIGHT, 1);
    send_pixel(16'h0080);
    send_pixel(16'h0100);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      configure(rand_size(), rand_size(), rand_scale(), rand_scale());
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) send_pixel(16'($urandom()));
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> pixel_replicate_scaler.f
src/pixrs_pkg.sv
src/pixrs_regs.sv
src/pixrs_ctrl.sv
src/pixrs_dp.sv
src/pixel_replicate_scaler.sv
sim/pixel_replicate_scaler_tb.sv
